FILE: rtl/pending_request_timeout_tracker_unit_macros.svh
// assertion macros for the pending request timeout tracker
`ifndef PENDING_REQUEST_TIMEOUT_TRACKER_UNIT_MACROS_SVH
`define PENDING_REQUEST_TIMEOUT_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTH
`define PRTT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PRTT_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);
`else
`define PRTT_ASSERT(lbl, prop, msg)
`define PRTT_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif

`endif

FILE: rtl/prtt_pkg.sv
// shared types and codes of the pending request timeout tracker
`default_nettype none

package prtt_pkg;

	localparam int MAX_RESULTS = 8;
	localparam int NW = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] OP_ISSUE    = 2'd0;
	localparam logic [1:0] OP_RESPONSE = 2'd1;
	localparam logic [1:0] OP_TIMEOUT  = 2'd2;

	localparam logic [1:0] RK_OK    = 2'd0;
	localparam logic [1:0] RK_ERROR = 2'd1;

	localparam logic [2:0] RS_ACCEPTED        = 3'd0;
	localparam logic [2:0] RS_FULL            = 3'd1;
	localparam logic [2:0] RS_OK              = 3'd2;
	localparam logic [2:0] RS_ERROR           = 3'd3;
	localparam logic [2:0] RS_TIMED_OUT       = 3'd4;
	localparam logic [2:0] RS_NONE_PENDING    = 3'd5;
	localparam logic [2:0] RS_DROPPED         = 3'd6;
	localparam logic [2:0] RS_NOTHING_EXPIRED = 3'd7;

	typedef struct packed {
		logic        vld;
		logic [4:0]  cmd;
		logic [31:0] dl;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic push;
		logic compact;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/prtt_cell.sv
// one queue cell: holds an entry, takes a pushed entry or its neighbor's entry on shift or compaction
`default_nettype none

module prtt_cell
	import prtt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       push_sel,
	input  entry_t     push_ent,
	input  entry_t     nxt,
	input  logic       chain_in,
	output logic       chain_out,
	output entry_t     cur
);

	logic        vld_q;
	logic [4:0]  cmd_q;
	logic [31:0] dl_q;
	logic        take_nxt;
	logic        take_push;

	// a cell moves once it or any older cell is a hole
	assign chain_out = !vld_q || chain_in;
	assign take_nxt  = ctrl.shift || (ctrl.compact && chain_out);
	assign take_push = ctrl.push && push_sel;
	assign cur       = '{vld: vld_q, cmd: cmd_q, dl: dl_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take_nxt) begin
			vld_q <= nxt.vld;
		end else if (take_push) begin
			vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_nxt) begin
			cmd_q <= nxt.cmd;
			dl_q  <= nxt.dl;
		end else if (take_push) begin
			cmd_q <= push_ent.cmd;
			dl_q  <= push_ent.dl;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pending_request_timeout_tracker_unit.sv
// top level of the pending request timeout tracker
`default_nettype none

// In-order tracker of outstanding requests kept in a row of QUEUE_DEPTH cells, oldest
// in the first cell. An issue or a response gives one item. A timeout check is accepted,
// then rotates the whole row once through the first cell, comparing one deadline per
// cycle while result items are not stalled, gives the final item, and then closes the
// gaps left by expired entries at one gap per cycle. Up to eight entries expire per
// check, oldest first. The slot reported is the queue position modulo the depth, low
// three bits.

`include "pending_request_timeout_tracker_unit_macros.svh"

module pending_request_timeout_tracker_unit
	import prtt_pkg::*;
#(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  operation,
	input  logic [4:0]  command_index,
	input  logic [15:0] timeout_ms,
	input  logic [31:0] now_ms,
	input  logic [1:0]  response_kind,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  status,
	output logic [4:0]  command_index_res,
	output logic [2:0]  slot,
	output logic        last
);

	localparam int SW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW:0] DEPTH_W = (CW + 1)'(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_SCAN    = 4'b0010,
		S_FINISH  = 4'b0100,
		S_COMPACT = 4'b1000
	} state_t;

	state_t          state_q;
	logic [SW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [SW-1:0]   step_q;
	logic [SW-1:0]   scan_slot_q;
	logic [NW-1:0]   n_q;
	logic [31:0]     now_q;
	logic            pend_vld_q;
	logic [4:0]      pend_cmd_q;
	logic [SW-1:0]   pend_slot_q;

	logic            res_valid_q;
	logic [2:0]      status_q;
	logic [4:0]      cmd_res_q;
	logic [2:0]      slot_q;
	logic            last_q;

	entry_t          cell_ent [QUEUE_DEPTH];
	entry_t          nxt_ent [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] chain;
	logic [QUEUE_DEPTH-1:0] push_sel;
	logic [QUEUE_DEPTH-1:0] vld_vec;
	logic [QUEUE_DEPTH-1:0] vld_expect;
	cell_ctrl_t      ctrl;
	entry_t          push_ent;
	entry_t          rot_ent;

	logic            out_free;
	logic            take;
	logic            full;
	logic            expired;
	logic [CW:0]     tail_sum;
	logic [SW-1:0]   tail_slot;

	logic            out_load;
	logic [2:0]      out_status_d;
	logic [4:0]      out_cmd_d;
	logic [SW-1:0]   out_slot_d;
	logic            out_last_d;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == SW'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	assign out_free  = !res_valid_q || !res_stall;
	assign req_stall = (state_q != S_IDLE) || !out_free;
	assign take      = req_valid && !req_stall;
	assign full      = count_q >= CW'(QUEUE_DEPTH);

	assign tail_sum  = (CW + 1)'(head_q) + (CW + 1)'(count_q);
	assign tail_slot = (tail_sum >= DEPTH_W) ? SW'(tail_sum - DEPTH_W) : SW'(tail_sum);

	assign expired = cell_ent[0].vld && (now_q > cell_ent[0].dl) &&
		(n_q < NW'(MAX_RESULTS));

	assign push_ent = '{vld: 1'b1, cmd: command_index, dl: now_ms + {16'b0, timeout_ms}};
	assign rot_ent  = '{vld: cell_ent[0].vld && !expired, cmd: cell_ent[0].cmd,
		dl: cell_ent[0].dl};

	assign ctrl.shift = (take && operation == OP_RESPONSE && count_q != '0) ||
		(state_q == S_SCAN && out_free);
	assign ctrl.push    = take && operation == OP_ISSUE && !full;
	assign ctrl.compact = state_q == S_COMPACT;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		if (i == QUEUE_DEPTH - 1) begin : g_end
			assign nxt_ent[i] = (state_q == S_SCAN) ? rot_ent : '0;
		end else begin : g_mid
			assign nxt_ent[i] = cell_ent[i + 1];
		end
		assign push_sel[i]   = CW'(i) == count_q;
		assign vld_vec[i]    = cell_ent[i].vld;
		assign vld_expect[i] = CW'(i) < count_q;

		prtt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.push_sel  (push_sel[i]),
			.push_ent  (push_ent),
			.nxt       (nxt_ent[i]),
			.chain_in  ((i == 0) ? 1'b0 : chain[(i == 0) ? 0 : i - 1]),
			.chain_out (chain[i]),
			.cur       (cell_ent[i])
		);
	end

	always_comb begin
		out_load     = 1'b0;
		out_status_d = RS_NOTHING_EXPIRED;
		out_cmd_d    = '0;
		out_slot_d   = '0;
		out_last_d   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (operation)
						OP_ISSUE: begin
							out_load  = 1'b1;
							out_cmd_d = command_index;
							if (full) begin
								out_status_d = RS_FULL;
							end else begin
								out_status_d = RS_ACCEPTED;
								out_slot_d   = tail_slot;
							end
						end
						OP_RESPONSE: begin
							out_load = 1'b1;
							if (count_q == '0) begin
								out_status_d = RS_NONE_PENDING;
							end else begin
								out_cmd_d  = cell_ent[0].cmd;
								out_slot_d = head_q;
								case (response_kind)
									RK_OK:    out_status_d = RS_OK;
									RK_ERROR: out_status_d = RS_ERROR;
									default:  out_status_d = RS_DROPPED;
								endcase
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (out_free && expired && pend_vld_q) begin
					out_load     = 1'b1;
					out_status_d = RS_TIMED_OUT;
					out_cmd_d    = pend_cmd_q;
					out_slot_d   = pend_slot_q;
					out_last_d   = 1'b0;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					if (pend_vld_q) begin
						out_status_d = RS_TIMED_OUT;
						out_cmd_d    = pend_cmd_q;
						out_slot_d   = pend_slot_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			step_q      <= '0;
			n_q         <= '0;
			pend_vld_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						case (operation)
							OP_ISSUE: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
							OP_RESPONSE: begin
								if (count_q != '0) begin
									head_q  <= slot_inc(head_q);
									count_q <= count_q - 1'b1;
								end
							end
							OP_TIMEOUT: begin
								state_q    <= S_SCAN;
								step_q     <= '0;
								n_q        <= '0;
								pend_vld_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (out_free) begin
						step_q <= step_q + 1'b1;
						if (expired) begin
							n_q        <= n_q + 1'b1;
							pend_vld_q <= 1'b1;
						end
						if (step_q == SW'(QUEUE_DEPTH - 1)) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						count_q    <= count_q - CW'(n_q);
						pend_vld_q <= 1'b0;
						state_q    <= (n_q == '0) ? S_IDLE : S_COMPACT;
					end
				end
				S_COMPACT: begin
					n_q <= n_q - 1'b1;
					if (n_q == NW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && operation == OP_TIMEOUT) begin
			now_q       <= now_ms;
			scan_slot_q <= head_q;
		end else if (state_q == S_SCAN && out_free) begin
			scan_slot_q <= slot_inc(scan_slot_q);
		end
		if (state_q == S_SCAN && out_free && expired) begin
			pend_cmd_q  <= cell_ent[0].cmd;
			pend_slot_q <= scan_slot_q;
		end
		if (out_load) begin
			status_q  <= out_status_d;
			cmd_res_q <= out_cmd_d;
			slot_q    <= 3'(out_slot_d);
			last_q    <= out_last_d;
		end
	end

	assign res_valid         = res_valid_q;
	assign status            = status_q;
	assign command_index_res = cmd_res_q;
	assign slot              = slot_q;
	assign last              = last_q;

	`PRTT_ASSERT(a_count_range, count_q <= CW'(QUEUE_DEPTH), "entry count beyond queue depth")
	`PRTT_ASSERT(a_idle_cells, (state_q == S_IDLE) |-> (vld_vec == vld_expect), "cells not packed")
	`PRTT_ASSERT(a_busy_stall, (state_q != S_IDLE) |-> req_stall, "item taken during check")
	`PRTT_ASSERT(a_compact_hole, (state_q == S_COMPACT) |-> chain[QUEUE_DEPTH-1], "no gap left")
	`PRTT_ASSERT_NEXT(a_finish_none, state_q == S_FINISH && out_free && n_q == '0, res_valid && status == RS_NOTHING_EXPIRED, "missing nothing expired item")

endmodule

`default_nettype wire
